[src/npfd_pkg.sv]
package npfd_pkg;

  localparam int MaxPrefixes   = 64;
  localparam int MaxPrefixBits = 32;

  typedef enum logic [2:0] {
    ST_ACCEPT   = 3'd0,
    ST_DUP      = 3'd1,
    ST_BADLEN   = 3'd2,
    ST_LEFTOVER = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_ADDR,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    LK_IDLE,
    LK_SCAN,
    LK_RESOLVE
  } lk_state_e;

  typedef struct packed {
    logic        start;
    logic        clear;
    logic [31:0] addr;
    logic [5:0]  len;
    logic        last;
  } lk_req_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] addr;
    logic [5:0]  len;
    logic        done;
  } res_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'd0;
    end else begin
      m = 32'hFFFF_FFFF << (6'd32 - len);
    end
    return m;
  endfunction

endpackage

[src/npfd_if.sv]
interface npfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface npfd_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] prefix_addr;
  logic [5:0]  prefix_length;
  logic        field_done;

  modport source (output valid, output status, output prefix_addr, output prefix_length,
                  output field_done, input ready);
  modport sink (input valid, input status, input prefix_addr, input prefix_length,
                input field_done, output ready);
endinterface

[src/npfd_parser.sv]
module npfd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              skip_i,
  output npfd_pkg::lk_req_t req_o,
  output npfd_pkg::res_t    res_o
);
  import npfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  bl_q, bl_d;
  logic [5:0]  len_q, len_d;
  logic [31:0] acc_q, acc_d;

  logic [2:0]  nb;
  logic [2:0]  total;
  logic [1:0]  pos;
  logic [31:0] acc_new;
  logic [2:0]  bl_new;

  always_comb begin
    nb      = 3'((9'(data_byte_i) + 9'd7) >> 3);
    total   = 3'((7'(len_q) + 7'd7) >> 3);
    pos     = 2'(total - bl_q);
    acc_new = acc_q | (32'(data_byte_i) << (5'd24 - {pos, 3'b000}));
    bl_new  = bl_q - 3'd1;
  end

  always_comb begin
    phase_d = phase_q;
    bl_d    = bl_q;
    len_d   = len_q;
    acc_d   = acc_q;
    req_o   = '0;
    res_o   = '0;
    if (skip_i) begin
      phase_d = PH_SKIP;
    end
    if (accept_i) begin
      case (phase_q)
        PH_SKIP: begin
          if (last_byte_i) begin
            phase_d     = PH_LENGTH;
            bl_d        = 3'd0;
            len_d       = 6'd0;
            acc_d       = 32'd0;
            req_o.clear = 1'b1;
          end
        end
        PH_LENGTH: begin
          if (data_byte_i > 8'(MaxPrefixBits)) begin
            res_o.valid  = 1'b1;
            res_o.status = ST_BADLEN;
            res_o.done   = last_byte_i;
            if (last_byte_i) begin
              phase_d     = PH_LENGTH;
              req_o.clear = 1'b1;
            end else begin
              phase_d = PH_SKIP;
            end
          end else if (nb == 3'd0) begin
            req_o.start = 1'b1;
            req_o.last  = last_byte_i;
            bl_d        = 3'd0;
            len_d       = 6'd0;
            acc_d       = 32'd0;
          end else if (last_byte_i) begin
            res_o.valid  = 1'b1;
            res_o.status = ST_LEFTOVER;
            res_o.len    = 6'(data_byte_i);
            res_o.done   = 1'b1;
            req_o.clear  = 1'b1;
            bl_d         = 3'd0;
            len_d        = 6'd0;
            acc_d        = 32'd0;
          end else begin
            phase_d = PH_ADDR;
            len_d   = 6'(data_byte_i);
            acc_d   = 32'd0;
            bl_d    = nb;
          end
        end
        PH_ADDR: begin
          if (bl_new != 3'd0) begin
            if (last_byte_i) begin
              res_o.valid  = 1'b1;
              res_o.status = ST_LEFTOVER;
              res_o.len    = len_q;
              res_o.done   = 1'b1;
              req_o.clear  = 1'b1;
              phase_d      = PH_LENGTH;
              bl_d         = 3'd0;
              len_d        = 6'd0;
              acc_d        = 32'd0;
            end else begin
              acc_d = acc_new;
              bl_d  = bl_new;
            end
          end else begin
            req_o.start = 1'b1;
            req_o.last  = last_byte_i;
            req_o.addr  = acc_new & prefix_mask(len_q);
            req_o.len   = len_q;
            phase_d     = PH_LENGTH;
            bl_d        = 3'd0;
            acc_d       = acc_new;
            if (last_byte_i) begin
              len_d = 6'd0;
              acc_d = 32'd0;
            end
          end
        end
        default: phase_d = PH_LENGTH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LENGTH;
      bl_q    <= 3'd0;
      len_q   <= 6'd0;
      acc_q   <= 32'd0;
    end else begin
      phase_q <= phase_d;
      bl_q    <= bl_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
    end
  end

endmodule

[src/npfd_lookup.sv]
module npfd_lookup #(
  parameter int MAX_PREFIXES = npfd_pkg::MaxPrefixes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npfd_pkg::lk_req_t req_i,
  input  logic              out_free_i,
  output logic              idle_o,
  output logic              skip_o,
  output npfd_pkg::res_t    rsp_o
);
  import npfd_pkg::*;

  localparam int CW = $clog2(MAX_PREFIXES + 1);
  localparam int AW = (MAX_PREFIXES > 1) ? $clog2(MAX_PREFIXES) : 1;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_PREFIXES);

  lk_state_e   state_q, state_d;
  logic [CW-1:0] used_q, used_d;
  logic [CW-1:0] idx_q, idx_d;
  logic        pend_q;
  logic        hit_q, hit_d;
  logic        last_q, last_d;
  logic [37:0] key_q, key_d;
  logic [37:0] rd_data_q;
  logic [37:0] mem [MAX_PREFIXES];

  logic rd_en;
  logic wr_en;
  logic match;
  logic full;

  assign match  = pend_q && (rd_data_q == key_q);
  assign full   = (used_q >= MaxCount);
  assign idle_o = (state_q == LK_IDLE);

  // outputs
  always_comb begin
    rd_en  = 1'b0;
    wr_en  = 1'b0;
    skip_o = 1'b0;
    rsp_o  = '0;
    case (state_q)
      LK_SCAN: rd_en = (idx_q < used_q);
      LK_RESOLVE: begin
        if (out_free_i) begin
          rsp_o.valid = 1'b1;
          rsp_o.done  = last_q;
          if (hit_q) begin
            rsp_o.status = ST_DUP;
            rsp_o.addr   = key_q[31:0];
            rsp_o.len    = key_q[37:32];
          end else if (full) begin
            rsp_o.status = ST_FULL;
            skip_o       = !last_q;
          end else begin
            rsp_o.status = ST_ACCEPT;
            rsp_o.addr   = key_q[31:0];
            rsp_o.len    = key_q[37:32];
            wr_en        = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    idx_d   = idx_q;
    hit_d   = hit_q;
    last_d  = last_q;
    key_d   = key_q;
    case (state_q)
      LK_IDLE: begin
        if (req_i.start) begin
          state_d = LK_SCAN;
          idx_d   = '0;
          hit_d   = 1'b0;
          last_d  = req_i.last;
          key_d   = {req_i.len, req_i.addr};
        end else if (req_i.clear) begin
          used_d = '0;
        end
      end
      LK_SCAN: begin
        if (rd_en) begin
          idx_d = idx_q + CW'(1);
        end
        if (match || !rd_en) begin
          hit_d   = match;
          state_d = LK_RESOLVE;
        end
      end
      LK_RESOLVE: begin
        if (out_free_i) begin
          state_d = LK_IDLE;
          if (last_q) begin
            used_d = '0;
          end else if (wr_en) begin
            used_d = used_q + CW'(1);
          end
        end
      end
      default: state_d = LK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LK_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      pend_q  <= rd_en;
      hit_q   <= hit_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // seen-prefix table, one write and one read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[used_q[AW-1:0]] <= key_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= MaxCount)
    else $error("table fill count beyond depth");

  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == LK_IDLE) && req_i.start |=> (state_q == LK_SCAN))
    else $error("lookup did not start scanning");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (used_q < MaxCount) && !hit_q)
    else $error("write into full table or on duplicate");

  a_accept_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == ST_ACCEPT) && !last_q
    |=> used_q == $past(used_q) + CW'(1))
    else $error("accepted prefix not counted");

endmodule

[src/nlri_prefix_field_decoder_unit.sv]
// IPv4 prefix field decoder.
// byte_i carries one byte of a prefix field per beat, last_byte marking the
// field's final byte. res_o carries at most one result per input beat:
// status, masked prefix address, prefix length and field_done.
// A byte that completes no prefix does not start a table lookup; errors found by the
// parser (bad length, leftover bytes) appear in the output register on the
// cycle after the byte is taken.
// A completed prefix is checked against the seen-prefix table, a synchronous
// memory with one write and one read port, read one entry per cycle; the scan
// of the entries stored in the field stops at the first match, and the next
// byte is held off until the lookup has put its result into the output register.
// The table is emptied at every field end by resetting its fill count, so
// no clearing pass is needed after reset.
// Reset returns the parser to expecting a length byte with an empty table.
// A single output register holds the result; while the receiver stalls and
// the register is full, byte_i.ready stays low.
module nlri_prefix_field_decoder_unit #(
  parameter int MAX_PREFIXES = npfd_pkg::MaxPrefixes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  npfd_byte_if.sink   byte_i,
  npfd_res_if.source  res_o
);
  import npfd_pkg::*;

  lk_req_t req;
  res_t    parse_res;
  res_t    lk_res;
  res_t    res_q;
  logic    out_valid_q;
  logic    out_free;
  logic    lk_idle;
  logic    lk_skip;
  logic    accept;

  assign out_free     = !out_valid_q || res_o.ready;
  assign byte_i.ready = lk_idle && out_free;
  assign accept       = byte_i.valid && byte_i.ready;

  npfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (byte_i.data_byte),
    .last_byte_i (byte_i.last_byte),
    .skip_i      (lk_skip),
    .req_o       (req),
    .res_o       (parse_res)
  );

  npfd_lookup #(
    .MAX_PREFIXES (MAX_PREFIXES)
  ) u_lookup (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .out_free_i (out_free),
    .idle_o     (lk_idle),
    .skip_o     (lk_skip),
    .rsp_o      (lk_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (parse_res.valid || lk_res.valid) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (parse_res.valid) begin
      res_q <= parse_res;
    end else if (lk_res.valid) begin
      res_q <= lk_res;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = res_q.status;
  assign res_o.prefix_addr   = res_q.addr;
  assign res_o.prefix_length = res_q.len;
  assign res_o.field_done    = res_q.done;

endmodule

[sim/nlri_result_checker.sv]
`timescale 1ns / 100ps

module nlri_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  npfd_byte_if        byte_i,
  npfd_res_if         res_i,
  output int unsigned errors_o,
  output int unsigned outstanding_o
);
  import npfd_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [31:0] addr;
    logic [5:0]  len;
    logic        done;
  } prefix_result_t;

  phase_e         parse_ph;
  logic [2:0]     addr_bytes_left;
  logic [5:0]     cur_len;
  logic [31:0]    addr_acc;
  logic [37:0]    seen_prefixes [MaxPrefixes];
  int unsigned    seen_count;
  int unsigned    mismatch_count;
  prefix_result_t results_due [$];

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    return ~(32'hFFFF_FFFF >> len);
  endfunction

  task automatic clear_field();
    parse_ph        = PH_LENGTH;
    addr_bytes_left = 3'd0;
    cur_len         = 6'd0;
    addr_acc        = 32'd0;
    seen_count      = 0;
  endtask

  task automatic push_result(input status_e st, input logic [31:0] a, input logic [5:0] l,
                             input logic d);
    prefix_result_t r;
    r.status = st;
    r.addr   = a;
    r.len    = l;
    r.done   = d;
    results_due.insert(results_due.size(), r);
  endtask

  task automatic store_prefix(input logic [31:0] a, input logic [5:0] l, output status_e st);
    logic [37:0] key;
    bit          hit;
    key = {l, a};
    hit = 1'b0;
    for (int i = 0; i < seen_count; i++) begin
      if (seen_prefixes[i] == key) hit = 1'b1;
    end
    if (hit) begin
      st = ST_DUP;
    end else if (seen_count >= MaxPrefixes) begin
      st = ST_FULL;
    end else begin
      seen_prefixes[seen_count] = key;
      seen_count++;
      st = ST_ACCEPT;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last);
    status_e     st;
    logic [2:0]  total;
    logic [1:0]  pos;
    logic [31:0] masked;
    case (parse_ph)
      PH_SKIP: begin
        if (last) clear_field();
      end
      PH_LENGTH: begin
        if (b > MaxPrefixBits) begin
          push_result(ST_BADLEN, 32'd0, 6'd0, last);
          if (last) clear_field();
          else parse_ph = PH_SKIP;
        end else begin
          cur_len         = b[5:0];
          addr_acc        = 32'd0;
          addr_bytes_left = 3'((b + 8'd7) >> 3);
          if (addr_bytes_left == 3'd0) begin
            store_prefix(32'd0, 6'd0, st);
            push_result(st, 32'd0, 6'd0, last);
            if (last) clear_field();
            else if (st == ST_FULL) parse_ph = PH_SKIP;
          end else if (last) begin
            push_result(ST_LEFTOVER, 32'd0, cur_len, 1'b1);
            clear_field();
          end else begin
            parse_ph = PH_ADDR;
          end
        end
      end
      default: begin
        total           = 3'((cur_len + 6'd7) >> 3);
        pos             = 2'(total - addr_bytes_left);
        addr_acc        = addr_acc | (32'(b) << (24 - 8 * pos));
        addr_bytes_left = addr_bytes_left - 3'd1;
        if (addr_bytes_left != 3'd0) begin
          if (last) begin
            push_result(ST_LEFTOVER, 32'd0, cur_len, 1'b1);
            clear_field();
          end
        end else begin
          masked = addr_acc & len_mask(cur_len);
          store_prefix(masked, cur_len, st);
          if (st == ST_FULL) push_result(st, 32'd0, 6'd0, last);
          else push_result(st, masked, cur_len, last);
          if (last) clear_field();
          else parse_ph = (st == ST_FULL) ? PH_SKIP : PH_LENGTH;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    prefix_result_t exp_res;
    if (!rst_ni) begin
      clear_field();
      results_due.delete();
      mismatch_count = 0;
    end else begin
      // result beat first: it always belongs to an earlier byte beat
      if (res_i.valid && res_i.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d addr=%h len=%0d done=%0b",
                   $time, res_i.status, res_i.prefix_addr, res_i.prefix_length,
                   res_i.field_done);
          mismatch_count++;
        end else begin
          exp_res = results_due.pop_front();
          if (res_i.status !== exp_res.status || res_i.prefix_addr !== exp_res.addr ||
              res_i.prefix_length !== exp_res.len || res_i.field_done !== exp_res.done) begin
            $display("%0t: mismatch expected status=%0d addr=%h len=%0d done=%0b",
                     $time, exp_res.status, exp_res.addr, exp_res.len, exp_res.done);
            $display("%0t:          actual   status=%0d addr=%h len=%0d done=%0b",
                     $time, res_i.status, res_i.prefix_addr, res_i.prefix_length,
                     res_i.field_done);
            mismatch_count++;
          end
        end
      end
      if (byte_i.valid && byte_i.ready) decode_byte(byte_i.data_byte, byte_i.last_byte);
    end
    errors_o      <= mismatch_count;
    outstanding_o <= results_due.size();
  end

endmodule

[sim/tb_nlri_prefix_field_decoder_unit.sv]
`timescale 1ns / 100ps

module tb_nlri_prefix_field_decoder_unit;
  import npfd_pkg::*;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatches;
  int unsigned results_waiting;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          long_stall_req  = 1'b0;
  bit          long_stall_done = 1'b0;
  int unsigned bytes_sent;
  logic [7:0]  field_q [$];

  npfd_byte_if byte_ch ();
  npfd_res_if  res_ch ();

  nlri_prefix_field_decoder_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch),
    .res_o  (res_ch)
  );

  nlri_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_i        (byte_ch),
    .res_i         (res_ch),
    .errors_o      (mismatches),
    .outstanding_o (results_waiting)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side, with one long hold-off once the last phase starts
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_req && !long_stall_done) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_stall_done = 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= b;
    byte_ch.last_byte <= last;
    do @(posedge clk_i); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    field_q.insert(field_q.size(), b);
  endtask

  task automatic push_prefix(input int unsigned len, input logic [31:0] addr);
    add_byte(8'(len));
    for (int k = 0; k < (len + 7) / 8; k++) add_byte(addr[31 - 8 * k -: 8]);
  endtask

  // noisy fields also carry stray last flags in the middle
  task automatic send_field(input bit noisy);
    for (int k = 0; k < field_q.size(); k++) begin
      send_byte(field_q[k], (k == field_q.size() - 1) || (noisy && $urandom_range(4) == 0));
    end
    field_q.delete();
  endtask

  function automatic int unsigned rand_len();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return 32;
    if (r < 4) return 8 * $urandom_range(1, 4);
    return $urandom_range(1, 31);
  endfunction

  task automatic gen_field(input int unsigned field_no);
    int unsigned kind;
    int unsigned n;
    int unsigned len;
    int unsigned pick;
    logic [31:0] addr;
    int unsigned used_len [$];
    logic [31:0] used_addr [$];
    if (field_no % 25 == 3) begin
      // fill the table, hit a duplicate, then overflow it
      for (int j = 0; j < MaxPrefixes; j++) push_prefix(16, {16'(j), 16'($urandom)});
      push_prefix(16, {16'd0, 16'($urandom)});
      if ($urandom_range(1)) push_prefix(0, 32'd0);
      else push_prefix($urandom_range(17, 32), $urandom);
      n = $urandom_range(0, 3);
      for (int j = 0; j < n; j++) push_prefix(rand_len(), $urandom);
      send_field(1'b0);
      return;
    end
    kind = $urandom_range(99);
    n    = $urandom_range((kind < 75) ? 1 : 0, 8);
    for (int j = 0; j < n; j++) begin
      if (used_len.size() > 0 && $urandom_range(3) == 0) begin
        pick = $urandom_range(used_len.size() - 1);
        len  = used_len[pick];
        addr = used_addr[pick] | ($urandom & (32'hFFFF_FFFF >> len));
      end else begin
        len  = rand_len();
        addr = $urandom;
      end
      push_prefix(len, addr);
      used_len.insert(used_len.size(), len);
      used_addr.insert(used_addr.size(), addr);
    end
    if (kind < 75) begin
      send_field(1'b0);
    end else if (kind < 85) begin
      len = $urandom_range(1, 32);
      add_byte(8'(len));
      n = $urandom_range(0, (len + 7) / 8 - 1);
      for (int j = 0; j < n; j++) add_byte(8'($urandom));
      send_field(1'b0);
    end else if (kind < 93) begin
      add_byte(8'($urandom_range(33, 255)));
      n = $urandom_range(0, 4);
      for (int j = 0; j < n; j++) add_byte(8'($urandom));
      send_field(1'b0);
    end else begin
      n = $urandom_range(1, 12);
      for (int j = 0; j < n; j++) add_byte(8'($urandom));
      send_field(1'b1);
    end
  endtask

  initial begin
    int unsigned start_count;
    int unsigned field_no;
    byte_ch.valid     <= 1'b0;
    byte_ch.data_byte <= 8'd0;
    byte_ch.last_byte <= 1'b0;
    src_idle_pct = 37;
    snk_idle_pct = 55;
    bytes_sent   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero length prefix alone
    push_prefix(0, 32'd0);
    send_field(1'b0);
    // full length, its duplicate, then a bad length skipped to the field end
    push_prefix(32, 32'hFFFF_FFFF);
    push_prefix(32, 32'hFFFF_FFFF);
    add_byte(8'd33);
    add_byte(8'h55);
    add_byte(8'h00);
    send_field(1'b0);
    // bad length on the last byte
    add_byte(8'd255);
    send_field(1'b0);
    // field ends inside the address bytes
    add_byte(8'd20);
    add_byte(8'hAB);
    add_byte(8'hCD);
    send_field(1'b0);
    // field ends on a length byte that needs address bytes
    add_byte(8'd9);
    send_field(1'b0);
    // masking, then zero length twice
    push_prefix(1, 32'hFFFF_FFFF);
    push_prefix(0, 32'd0);
    push_prefix(0, 32'd0);
    send_field(1'b0);
    // table emptied at the previous field end
    push_prefix(0, 32'd0);
    send_field(1'b0);

    start_count = bytes_sent;
    field_no    = 0;
    while (bytes_sent - start_count < 1000) begin
      if (bytes_sent - start_count >= 666) begin
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        long_stall_req = 1'b1;
      end else if (bytes_sent - start_count >= 333) begin
        src_idle_pct = 55;
        snk_idle_pct = 37;
      end
      gen_field(field_no);
      field_no++;
    end
    byte_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (results_waiting != 0) @(posedge clk_i);
    repeat (MaxPrefixes + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
src/npfd_pkg.sv
src/npfd_if.sv
src/npfd_parser.sv
src/npfd_lookup.sv
src/nlri_prefix_field_decoder_unit.sv
sim/nlri_result_checker.sv
sim/tb_nlri_prefix_field_decoder_unit.sv
